### sv/bgt_pkg.sv
// Package with the item types, codes and character constants of the grammar tokenizer.
`default_nettype none
package bgt_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		KIND_EOF  = 4'd0,
		KIND_DEF  = 4'd1,
		KIND_TERM = 4'd2,
		KIND_ALT  = 4'd3,
		KIND_EPS  = 4'd4,
		KIND_STR  = 4'd5,
		KIND_RE   = 4'd6,
		KIND_EX   = 4'd7,
		KIND_CM   = 4'd8,
		KIND_NT   = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_BRACKET = 3'd1,
		ERR_NT      = 3'd2,
		ERR_SPACE   = 3'd3,
		ERR_REGEX   = 3'd4,
		ERR_STAR    = 3'd5,
		ERR_UNEXP   = 3'd6,
		ERR_UNTERM  = 3'd7
	} err_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_STR     = 4'd1,
		MODE_RE      = 4'd2,
		MODE_RE_U    = 4'd3,
		MODE_EX_OPEN = 4'd4,
		MODE_EX_RE   = 4'd5,
		MODE_EX_RE_U = 4'd6,
		MODE_EX_SP   = 4'd7,
		MODE_EX_NT1  = 4'd8,
		MODE_EX_NT   = 4'd9,
		MODE_CM_OPEN = 4'd10,
		MODE_CM      = 4'd11,
		MODE_NT      = 4'd12,
		MODE_DONE    = 4'd13
	} mode_t;

	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		kind_t      token_kind;
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_last;
		err_t       error_code;
	} res_item_t;

	typedef struct packed {
		logic      two;
		res_item_t r0;
		res_item_t r1;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic res_item_t make_item(input kind_t k, input logic [7:0] b,
			input logic v, input logic l, input err_t e);
		res_item_t r;
		r.token_kind = k;
		r.token_byte = v ? b : 8'h00;
		r.byte_valid = v;
		r.token_last = l;
		r.error_code = e;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage
`default_nettype wire

### sv/bgt_stream_if.sv
// Valid/ready stream interface carrying one request per handshake.
`default_nettype none
interface bgt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/bgt_front.sv
// Front end: accepts characters, runs the lexer mode machine and queues result pairs.
`default_nettype none
module bgt_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	bgt_stream_if.sink    in_ch,
	input  wire bgt_pkg::q_stat_t stat,
	output bgt_pkg::q_push_t push
);

	typedef struct packed {
		bgt_pkg::mode_t     mode;
		logic [7:0]         prev;
		logic               empty;
		logic               halt;
		logic               has;
		bgt_pkg::res_item_t item;
	} start_t;

	function automatic start_t start_tok(input logic [7:0] c);
		start_t s;
		s.mode  = bgt_pkg::MODE_IDLE;
		s.prev  = 8'h00;
		s.empty = 1'b1;
		s.halt  = 1'b0;
		s.has   = 1'b0;
		s.item  = '0;
		if (!bgt_pkg::is_space(c)) begin
			case (c)
				bgt_pkg::CH_EQ: begin
					s.has  = 1'b1;
					s.item = bgt_pkg::make_item(bgt_pkg::KIND_DEF, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
				end
				bgt_pkg::CH_SEMI: begin
					s.has  = 1'b1;
					s.item = bgt_pkg::make_item(bgt_pkg::KIND_TERM, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
				end
				bgt_pkg::CH_BAR: begin
					s.has  = 1'b1;
					s.item = bgt_pkg::make_item(bgt_pkg::KIND_ALT, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
				end
				bgt_pkg::CH_QUOTE: s.mode = bgt_pkg::MODE_STR;
				bgt_pkg::CH_SLASH: begin
					s.mode  = bgt_pkg::MODE_RE;
					s.prev  = c;
					s.empty = 1'b0;
					s.has   = 1'b1;
					s.item  = bgt_pkg::make_item(bgt_pkg::KIND_RE, c, 1'b1, 1'b0, bgt_pkg::ERR_OK);
				end
				bgt_pkg::CH_LBRACK: s.mode = bgt_pkg::MODE_EX_OPEN;
				bgt_pkg::CH_LPAREN: s.mode = bgt_pkg::MODE_CM_OPEN;
				default: begin
					s.has = 1'b1;
					if (bgt_pkg::is_alnum(c)) begin
						s.mode  = bgt_pkg::MODE_NT;
						s.prev  = c;
						s.empty = 1'b0;
						s.item  = bgt_pkg::make_item(bgt_pkg::KIND_NT, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
					end else begin
						s.halt = 1'b1;
						s.item = bgt_pkg::make_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_UNEXP);
					end
				end
			endcase
		end
		return s;
	endfunction

	function automatic bgt_pkg::kind_t mode_kind(input bgt_pkg::mode_t m);
		bgt_pkg::kind_t k;
		unique case (m)
			bgt_pkg::MODE_STR: k = bgt_pkg::KIND_STR;
			bgt_pkg::MODE_RE, bgt_pkg::MODE_RE_U: k = bgt_pkg::KIND_RE;
			bgt_pkg::MODE_CM_OPEN, bgt_pkg::MODE_CM: k = bgt_pkg::KIND_CM;
			bgt_pkg::MODE_NT: k = bgt_pkg::KIND_NT;
			bgt_pkg::MODE_IDLE, bgt_pkg::MODE_DONE: k = bgt_pkg::KIND_EOF;
			default: k = bgt_pkg::KIND_EX;
		endcase
		return k;
	endfunction

	bgt_pkg::mode_t     mode_q, nxt_mode;
	logic [7:0]         prev_q, nxt_prev;
	logic               empty_q, nxt_empty;
	logic               halted_q, nxt_halt;
	logic [1:0]         cnt;
	bgt_pkg::res_item_t r0, r1;
	start_t             st;
	logic [7:0]         c;
	logic               esc;
	logic               accept;

	assign c            = in_ch.data.ch;
	assign esc          = !empty_q && (prev_q == bgt_pkg::CH_BSLASH);
	assign in_ch.ready  = !stat.full;
	assign accept       = in_ch.valid && in_ch.ready;
	assign st           = start_tok(c);

	always_comb begin
		nxt_mode  = mode_q;
		nxt_prev  = prev_q;
		nxt_empty = empty_q;
		nxt_halt  = halted_q;
		cnt       = 2'd0;
		r0        = '0;
		r1        = '0;
		if (halted_q) begin
			cnt = 2'd0;
		end else if (mode_q == bgt_pkg::MODE_DONE) begin
			cnt = 2'd1;
			r0  = bgt_pkg::make_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
		end else if (in_ch.data.end_of_input) begin
			if (mode_q == bgt_pkg::MODE_NT || mode_q == bgt_pkg::MODE_RE_U) begin
				cnt      = 2'd2;
				r0       = bgt_pkg::make_item(mode_kind(mode_q), 8'h00, 1'b0, 1'b1,
					bgt_pkg::ERR_OK);
				r1       = bgt_pkg::make_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1,
					bgt_pkg::ERR_OK);
				nxt_mode = bgt_pkg::MODE_DONE;
			end else if (mode_q != bgt_pkg::MODE_IDLE) begin
				cnt      = 2'd1;
				r0       = bgt_pkg::make_item(mode_kind(mode_q), 8'h00, 1'b0, 1'b1,
					bgt_pkg::ERR_UNTERM);
				nxt_halt = 1'b1;
				nxt_mode = bgt_pkg::MODE_IDLE;
			end else begin
				cnt      = 2'd1;
				r0       = bgt_pkg::make_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1,
					bgt_pkg::ERR_OK);
				nxt_mode = bgt_pkg::MODE_DONE;
			end
		end else begin
			unique case (mode_q)
				bgt_pkg::MODE_STR: begin
					cnt = 2'd1;
					if (c == bgt_pkg::CH_QUOTE && !esc) begin
						r0       = bgt_pkg::make_item(empty_q ? bgt_pkg::KIND_EPS :
							bgt_pkg::KIND_STR, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_STR, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
					end
				end
				bgt_pkg::MODE_RE, bgt_pkg::MODE_EX_RE: begin
					cnt       = 2'd1;
					r0        = bgt_pkg::make_item((mode_q == bgt_pkg::MODE_RE) ?
						bgt_pkg::KIND_RE : bgt_pkg::KIND_EX, c, 1'b1, 1'b0, bgt_pkg::ERR_OK);
					nxt_prev  = c;
					nxt_empty = 1'b0;
					if (c == bgt_pkg::CH_SLASH && !esc) begin
						nxt_mode = (mode_q == bgt_pkg::MODE_RE) ? bgt_pkg::MODE_RE_U :
							bgt_pkg::MODE_EX_RE_U;
					end
				end
				bgt_pkg::MODE_RE_U: begin
					if (c == bgt_pkg::CH_U) begin
						cnt       = 2'd2;
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_RE, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						r1        = bgt_pkg::make_item(bgt_pkg::KIND_RE, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
						nxt_mode  = bgt_pkg::MODE_IDLE;
					end else begin
						cnt       = st.has ? 2'd2 : 2'd1;
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_RE, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_OK);
						r1        = st.item;
						nxt_mode  = st.mode;
						nxt_prev  = st.prev;
						nxt_empty = st.empty;
						nxt_halt  = st.halt;
					end
				end
				bgt_pkg::MODE_EX_OPEN: begin
					cnt = 2'd1;
					if (c != bgt_pkg::CH_SLASH) begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_REGEX);
						nxt_halt = 1'b1;
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_EX, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
						nxt_mode  = bgt_pkg::MODE_EX_RE;
					end
				end
				bgt_pkg::MODE_EX_RE_U, bgt_pkg::MODE_EX_SP: begin
					cnt = 2'd1;
					if (mode_q == bgt_pkg::MODE_EX_RE_U && c == bgt_pkg::CH_U) begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_EX, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
						nxt_mode  = bgt_pkg::MODE_EX_SP;
					end else if (!bgt_pkg::is_space(c)) begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_SPACE);
						nxt_halt = 1'b1;
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_EX, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
						nxt_mode  = bgt_pkg::MODE_EX_NT1;
					end
				end
				bgt_pkg::MODE_EX_NT1: begin
					cnt = 2'd1;
					if (!bgt_pkg::is_alnum(c)) begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_NT);
						nxt_halt = 1'b1;
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_EX, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
						nxt_mode  = bgt_pkg::MODE_EX_NT;
					end
				end
				bgt_pkg::MODE_EX_NT: begin
					cnt = 2'd1;
					if (bgt_pkg::is_alnum(c)) begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_EX, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
					end else if (c != bgt_pkg::CH_RBRACK) begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_BRACKET);
						nxt_halt = 1'b1;
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_OK);
						nxt_mode = bgt_pkg::MODE_IDLE;
					end
				end
				bgt_pkg::MODE_CM_OPEN: begin
					if (c != bgt_pkg::CH_STAR) begin
						cnt      = 2'd1;
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_CM, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_STAR);
						nxt_halt = 1'b1;
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						nxt_mode  = bgt_pkg::MODE_CM;
						nxt_empty = 1'b1;
					end
				end
				bgt_pkg::MODE_CM: begin
					cnt = 2'd1;
					if (c == bgt_pkg::CH_RPAREN && !empty_q &&
							prev_q == bgt_pkg::CH_STAR) begin
						r0       = bgt_pkg::make_item(bgt_pkg::KIND_CM, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_OK);
						nxt_mode = bgt_pkg::MODE_IDLE;
					end else begin
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_CM, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
					end
				end
				bgt_pkg::MODE_NT: begin
					if (bgt_pkg::is_alnum(c)) begin
						cnt       = 2'd1;
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_NT, c, 1'b1, 1'b0,
							bgt_pkg::ERR_OK);
						nxt_prev  = c;
						nxt_empty = 1'b0;
					end else begin
						cnt       = st.has ? 2'd2 : 2'd1;
						r0        = bgt_pkg::make_item(bgt_pkg::KIND_NT, 8'h00, 1'b0, 1'b1,
							bgt_pkg::ERR_OK);
						r1        = st.item;
						nxt_mode  = st.mode;
						nxt_prev  = st.prev;
						nxt_empty = st.empty;
						nxt_halt  = st.halt;
					end
				end
				default: begin
					cnt       = st.has ? 2'd1 : 2'd0;
					r0        = st.item;
					nxt_mode  = st.mode;
					nxt_prev  = st.prev;
					nxt_empty = st.empty;
					nxt_halt  = st.halt;
				end
			endcase
		end
	end

	assign push.push      = accept && (cnt != 2'd0);
	assign push.entry.two = (cnt == 2'd2);
	assign push.entry.r0  = r0;
	assign push.entry.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bgt_pkg::MODE_IDLE;
			prev_q   <= 8'h00;
			empty_q  <= 1'b1;
			halted_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= nxt_mode;
			prev_q   <= nxt_prev;
			empty_q  <= nxt_empty;
			halted_q <= nxt_halt;
		end
	end

endmodule
`default_nettype wire

### sv/bgt_queue.sv
// Back end: queue of result pairs that hands out one result per request.
`default_nettype none
module bgt_queue #(
	parameter int DEPTH = bgt_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bgt_pkg::q_push_t push,
	output bgt_pkg::q_stat_t stat,
	bgt_stream_if.source     out_ch
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bgt_pkg::entry_t  mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             sub_q;
	bgt_pkg::entry_t  head;
	logic             out_acc;
	logic             pop;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head         = mem[rd_ptr_q];
	assign stat.full    = (count_q == CNT_W'(DEPTH));
	assign stat.empty   = (count_q == '0);
	assign out_ch.valid = !stat.empty;
	assign out_ch.data  = sub_q ? head.r1 : head.r0;
	assign out_acc      = out_ch.valid && out_ch.ready;
	assign pop          = out_acc && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
				sub_q    <= 1'b0;
			end else if (out_acc) begin
				sub_q <= 1'b1;
			end
			if (push.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/bnf_grammar_tokenizer.sv
// Top level of the streaming BNF grammar tokenizer.
// The tokenizer takes one character request per cycle while the queue has a
// free entry and returns tagged token items: content bytes as they arrive and
// a closing item for each token. A character is classified in the cycle it is
// accepted and its zero, one or two results are written as one entry into a
// queue of QUEUE_DEPTH entries; the output side drains one result per cycle
// while the receiver is ready, so a character that closes a token and opens
// the next one yields two results from a single entry. After an error code the
// tokenizer swallows all further input until reset; after end of input it
// answers each further request with an end-of-input item.
`default_nettype none
module bnf_grammar_tokenizer #(
	parameter int QUEUE_DEPTH = bgt_pkg::QUEUE_DEPTH
) (
	input wire logic     clk,
	input wire logic     arst_n,
	bgt_stream_if.sink   in_ch,
	bgt_stream_if.source out_ch
);

	bgt_pkg::q_push_t push;
	bgt_pkg::q_stat_t stat;

	bgt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.stat   (stat),
		.push   (push)
	);

	bgt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.stat   (stat),
		.out_ch (out_ch)
	);

	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.data.error_code != bgt_pkg::ERR_OK) |->
			out_ch.data.token_last && !out_ch.data.byte_valid)
		else $error("error item must close its token without a byte");

	a_eps_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.data.token_kind == bgt_pkg::KIND_EPS) |->
			!out_ch.data.byte_valid && out_ch.data.token_last)
		else $error("epsilon item must carry no byte");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push.push)
		else $error("queue written while full");

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the streaming BNF grammar tokenizer.
module testbench;

	localparam int STALL_LIMIT = 400;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	logic clk;
	logic arst_n;

	bgt_stream_if #(.T(bgt_pkg::in_item_t)) in_ch();
	bgt_stream_if #(.T(bgt_pkg::res_item_t)) out_ch();

	bnf_grammar_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	bgt_pkg::res_item_t expected[$];
	logic [7:0] spell_q[$];
	int failures = 0;
	int checked = 0;
	int sent_chars = 0;
	bit calm = 1'b0;
	string ending = "";

	bgt_pkg::mode_t lex_state = bgt_pkg::MODE_IDLE;
	logic [7:0] last_content = 8'h00;
	bit content_empty = 1'b1;
	bit lexer_stopped = 1'b0;

	function automatic bit blank_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z");
	endfunction

	function automatic bgt_pkg::kind_t token_of(input bgt_pkg::mode_t m);
		case (m)
			bgt_pkg::MODE_STR: return bgt_pkg::KIND_STR;
			bgt_pkg::MODE_RE, bgt_pkg::MODE_RE_U: return bgt_pkg::KIND_RE;
			bgt_pkg::MODE_CM_OPEN, bgt_pkg::MODE_CM: return bgt_pkg::KIND_CM;
			bgt_pkg::MODE_NT: return bgt_pkg::KIND_NT;
			bgt_pkg::MODE_IDLE, bgt_pkg::MODE_DONE: return bgt_pkg::KIND_EOF;
			default: return bgt_pkg::KIND_EX;
		endcase
	endfunction

	function automatic void expect_item(input bgt_pkg::kind_t k, input logic [7:0] b,
			input bit v, input bit l, input bgt_pkg::err_t e);
		bgt_pkg::res_item_t r;
		r.token_kind = k;
		r.token_byte = v ? b : 8'h00;
		r.byte_valid = v;
		r.token_last = l;
		r.error_code = e;
		expected.push_back(r);
	endfunction

	function automatic void keep_content(input bgt_pkg::kind_t k, input logic [7:0] c);
		last_content = c;
		content_empty = 1'b0;
		expect_item(k, c, 1'b1, 1'b0, bgt_pkg::ERR_OK);
	endfunction

	function automatic void stop_lexer(input bgt_pkg::kind_t k, input bgt_pkg::err_t e);
		lexer_stopped = 1'b1;
		lex_state = bgt_pkg::MODE_IDLE;
		expect_item(k, 8'h00, 1'b0, 1'b1, e);
	endfunction

	function automatic void begin_token(input logic [7:0] c);
		lex_state = bgt_pkg::MODE_IDLE;
		content_empty = 1'b1;
		last_content = 8'h00;
		if (blank_char(c))
			return;
		case (c)
			bgt_pkg::CH_EQ: expect_item(bgt_pkg::KIND_DEF, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
			bgt_pkg::CH_SEMI: expect_item(bgt_pkg::KIND_TERM, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
			bgt_pkg::CH_BAR: expect_item(bgt_pkg::KIND_ALT, c, 1'b1, 1'b1, bgt_pkg::ERR_OK);
			bgt_pkg::CH_QUOTE: lex_state = bgt_pkg::MODE_STR;
			bgt_pkg::CH_SLASH: begin
				lex_state = bgt_pkg::MODE_RE;
				keep_content(bgt_pkg::KIND_RE, c);
			end
			bgt_pkg::CH_LBRACK: lex_state = bgt_pkg::MODE_EX_OPEN;
			bgt_pkg::CH_LPAREN: lex_state = bgt_pkg::MODE_CM_OPEN;
			default: begin
				if (word_char(c)) begin
					lex_state = bgt_pkg::MODE_NT;
					keep_content(bgt_pkg::KIND_NT, c);
				end else begin
					stop_lexer(bgt_pkg::KIND_EOF, bgt_pkg::ERR_UNEXP);
				end
			end
		endcase
	endfunction

	function automatic void lex_char(input logic [7:0] c, input logic eoi);
		bgt_pkg::mode_t m;
		bit escaped;
		m = lex_state;
		escaped = !content_empty && last_content == bgt_pkg::CH_BSLASH;
		if (lexer_stopped)
			return;
		if (m == bgt_pkg::MODE_DONE) begin
			expect_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
			return;
		end
		if (eoi) begin
			if (m == bgt_pkg::MODE_NT || m == bgt_pkg::MODE_RE_U) begin
				expect_item(token_of(m), 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
			end else if (m != bgt_pkg::MODE_IDLE) begin
				stop_lexer(token_of(m), bgt_pkg::ERR_UNTERM);
				return;
			end
			lex_state = bgt_pkg::MODE_DONE;
			expect_item(bgt_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
			return;
		end
		case (m)
			bgt_pkg::MODE_IDLE: begin_token(c);
			bgt_pkg::MODE_STR: begin
				if (c == bgt_pkg::CH_QUOTE && !escaped) begin
					expect_item(content_empty ? bgt_pkg::KIND_EPS : bgt_pkg::KIND_STR, 8'h00,
						1'b0, 1'b1, bgt_pkg::ERR_OK);
					lex_state = bgt_pkg::MODE_IDLE;
				end else begin
					keep_content(bgt_pkg::KIND_STR, c);
				end
			end
			bgt_pkg::MODE_RE, bgt_pkg::MODE_EX_RE: begin
				if (c == bgt_pkg::CH_SLASH && !escaped)
					lex_state = (m == bgt_pkg::MODE_RE) ? bgt_pkg::MODE_RE_U :
						bgt_pkg::MODE_EX_RE_U;
				keep_content((m == bgt_pkg::MODE_RE) ? bgt_pkg::KIND_RE : bgt_pkg::KIND_EX, c);
			end
			bgt_pkg::MODE_RE_U: begin
				if (c == bgt_pkg::CH_U) begin
					keep_content(bgt_pkg::KIND_RE, c);
					lex_state = bgt_pkg::MODE_IDLE;
					expect_item(bgt_pkg::KIND_RE, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
				end else begin
					expect_item(bgt_pkg::KIND_RE, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
					begin_token(c);
				end
			end
			bgt_pkg::MODE_EX_OPEN: begin
				if (c != bgt_pkg::CH_SLASH) begin
					stop_lexer(bgt_pkg::KIND_EX, bgt_pkg::ERR_REGEX);
				end else begin
					lex_state = bgt_pkg::MODE_EX_RE;
					keep_content(bgt_pkg::KIND_EX, c);
				end
			end
			bgt_pkg::MODE_EX_RE_U: begin
				if (c == bgt_pkg::CH_U) begin
					lex_state = bgt_pkg::MODE_EX_SP;
					keep_content(bgt_pkg::KIND_EX, c);
				end else if (!blank_char(c)) begin
					stop_lexer(bgt_pkg::KIND_EX, bgt_pkg::ERR_SPACE);
				end else begin
					lex_state = bgt_pkg::MODE_EX_NT1;
					keep_content(bgt_pkg::KIND_EX, c);
				end
			end
			bgt_pkg::MODE_EX_SP: begin
				if (!blank_char(c)) begin
					stop_lexer(bgt_pkg::KIND_EX, bgt_pkg::ERR_SPACE);
				end else begin
					lex_state = bgt_pkg::MODE_EX_NT1;
					keep_content(bgt_pkg::KIND_EX, c);
				end
			end
			bgt_pkg::MODE_EX_NT1: begin
				if (!word_char(c)) begin
					stop_lexer(bgt_pkg::KIND_EX, bgt_pkg::ERR_NT);
				end else begin
					lex_state = bgt_pkg::MODE_EX_NT;
					keep_content(bgt_pkg::KIND_EX, c);
				end
			end
			bgt_pkg::MODE_EX_NT: begin
				if (word_char(c)) begin
					keep_content(bgt_pkg::KIND_EX, c);
				end else if (c != bgt_pkg::CH_RBRACK) begin
					stop_lexer(bgt_pkg::KIND_EX, bgt_pkg::ERR_BRACKET);
				end else begin
					lex_state = bgt_pkg::MODE_IDLE;
					expect_item(bgt_pkg::KIND_EX, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
				end
			end
			bgt_pkg::MODE_CM_OPEN: begin
				if (c != bgt_pkg::CH_STAR) begin
					stop_lexer(bgt_pkg::KIND_CM, bgt_pkg::ERR_STAR);
				end else begin
					lex_state = bgt_pkg::MODE_CM;
					content_empty = 1'b1;
				end
			end
			bgt_pkg::MODE_CM: begin
				if (c == bgt_pkg::CH_RPAREN && !content_empty &&
						last_content == bgt_pkg::CH_STAR) begin
					lex_state = bgt_pkg::MODE_IDLE;
					expect_item(bgt_pkg::KIND_CM, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
				end else begin
					keep_content(bgt_pkg::KIND_CM, c);
				end
			end
			bgt_pkg::MODE_NT: begin
				if (word_char(c)) begin
					keep_content(bgt_pkg::KIND_NT, c);
				end else begin
					expect_item(bgt_pkg::KIND_NT, 8'h00, 1'b0, 1'b1, bgt_pkg::ERR_OK);
					begin_token(c);
				end
			end
			default: begin_token(c);
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		bgt_pkg::res_item_t want;
		bgt_pkg::res_item_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				lex_char(in_ch.data.ch, in_ch.data.end_of_input);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected.size() == 0) begin
					failures++;
					$display("%0t: token item with nothing pending, expected none, got kind %0d byte %h",
						$time, got.token_kind, got.token_byte);
				end else begin
					want = expected.pop_front();
					checked++;
					compare_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
					compare_field("token_byte", want.token_byte, got.token_byte);
					compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
					compare_field("token_last", 8'(want.token_last), 8'(got.token_last));
					compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= calm || $urandom_range(99) >= 21;
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("stalled for %0d cycles at %0t", STALL_LIMIT, $time);
		$display("status: fail");
		$finish;
	end

	task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0);
		while (!calm && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= bgt_pkg::in_item_t'{ch: c, end_of_input: eoi};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent_chars++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain_wait();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (expected.size() != 0);
	endtask

	function automatic logic [7:0] blank_pick();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
	endfunction

	function automatic logic [7:0] word_pick();
		int r;
		r = $urandom_range(61);
		if (r < 10)
			return "0" + 8'(r);
		if (r < 36)
			return "A" + 8'(r - 10);
		return "a" + 8'(r - 36);
	endfunction

	// A closing delimiter inside the body always gets a backslash in front, and the
	// body never ends in a backslash, so the token stays well formed.
	function automatic void add_body(input logic [7:0] closer, input int len);
		logic [7:0] c;
		repeat (len) begin
			c = 8'($urandom_range(255));
			if ($urandom_range(7) == 0)
				c = closer;
			if (c == closer)
				spell_q.push_back(bgt_pkg::CH_BSLASH);
			spell_q.push_back(c);
		end
		if (spell_q[$] == bgt_pkg::CH_BSLASH)
			spell_q.push_back("a");
	endfunction

	function automatic void build_random_token();
		int pick;
		int len;
		logic [7:0] c;
		spell_q.delete();
		repeat ($urandom_range(2))
			spell_q.push_back(blank_pick());
		pick = $urandom_range(11);
		len = ($urandom_range(9) == 0) ? 14 : $urandom_range(5);
		case (pick)
			0: spell_q.push_back(bgt_pkg::CH_EQ);
			1: spell_q.push_back(bgt_pkg::CH_SEMI);
			2: spell_q.push_back(bgt_pkg::CH_BAR);
			3: begin
				spell_q.push_back(bgt_pkg::CH_QUOTE);
				spell_q.push_back(bgt_pkg::CH_QUOTE);
			end
			4, 5: begin
				spell_q.push_back(bgt_pkg::CH_QUOTE);
				add_body(bgt_pkg::CH_QUOTE, len);
				spell_q.push_back(bgt_pkg::CH_QUOTE);
			end
			6, 7: begin
				spell_q.push_back(bgt_pkg::CH_SLASH);
				add_body(bgt_pkg::CH_SLASH, len);
				spell_q.push_back(bgt_pkg::CH_SLASH);
				if ($urandom_range(1))
					spell_q.push_back(bgt_pkg::CH_U);
			end
			8: begin
				spell_q.push_back(bgt_pkg::CH_LBRACK);
				spell_q.push_back(bgt_pkg::CH_SLASH);
				add_body(bgt_pkg::CH_SLASH, len);
				spell_q.push_back(bgt_pkg::CH_SLASH);
				if ($urandom_range(1))
					spell_q.push_back(bgt_pkg::CH_U);
				spell_q.push_back(blank_pick());
				repeat (1 + $urandom_range(3))
					spell_q.push_back(word_pick());
				spell_q.push_back(bgt_pkg::CH_RBRACK);
			end
			9: begin
				spell_q.push_back(bgt_pkg::CH_LPAREN);
				spell_q.push_back(bgt_pkg::CH_STAR);
				repeat (len) begin
					c = 8'($urandom_range(255));
					if (c == bgt_pkg::CH_RPAREN && spell_q[$] == bgt_pkg::CH_STAR)
						c = "a";
					spell_q.push_back(c);
				end
				spell_q.push_back(bgt_pkg::CH_STAR);
				spell_q.push_back(bgt_pkg::CH_RPAREN);
			end
			default: begin
				repeat (1 + $urandom_range(7))
					spell_q.push_back(word_pick());
			end
		endcase
	endfunction

	task automatic test_single_tokens();
		send_text(";| ");
	endtask

	task automatic test_strings();
		send_text("\"\"");
		send_char(bgt_pkg::CH_QUOTE);
		send_char(8'h00);
		send_char(bgt_pkg::CH_BSLASH);
		send_char(bgt_pkg::CH_QUOTE);
		send_char(8'hFF);
		send_char(bgt_pkg::CH_QUOTE);
	endtask

	task automatic test_regex_and_lookahead();
		send_text("/\\//U");
		send_text("/a/z=");
	endtask

	task automatic test_exclusion();
		send_text("[/x/ A]");
	endtask

	task automatic test_comment();
		send_text("(**)");
	endtask

	task automatic test_random_grammar();
		bit paused;
		paused = 1'b0;
		while (sent_chars < 930) begin
			calm = sent_chars >= 350 && sent_chars < 550;
			if (!paused && sent_chars >= 650) begin
				drain_wait();
				paused = 1'b1;
			end
			build_random_token();
			for (int i = 0; i < spell_q.size(); i++)
				send_char(spell_q[i]);
		end
		calm = 1'b0;
	endtask

	// Errors stop the lexer until reset, so each run closes its stream in one of
	// these ways, picked at random, and then keeps sending into the stopped or ended lexer.
	task automatic test_stream_end();
		logic [7:0] c;
		case ($urandom_range(13))
			0: begin
				ending = "stray character";
				do begin
					c = 8'($urandom_range(255));
				end while (blank_char(c) || word_char(c) || c == bgt_pkg::CH_EQ ||
					c == bgt_pkg::CH_SEMI || c == bgt_pkg::CH_BAR || c == bgt_pkg::CH_QUOTE ||
					c == bgt_pkg::CH_SLASH || c == bgt_pkg::CH_LBRACK ||
					c == bgt_pkg::CH_LPAREN);
				send_char(c);
			end
			1: begin
				ending = "missing bracket";
				send_text("[/a/ Bc;");
			end
			2: begin
				ending = "missing exclusion name";
				send_text("[/a/ ;");
			end
			3: begin
				ending = "missing space";
				send_text("[/a/x");
			end
			4: begin
				ending = "missing space after flag";
				send_text("[/a/Ux");
			end
			5: begin
				ending = "missing exclusion regex";
				send_text("[a");
			end
			6: begin
				ending = "missing comment star";
				send_text("(a");
			end
			7: begin
				ending = "open string";
				send_text("\"ab");
			end
			8: begin
				ending = "open comment";
				send_text("(*ab");
			end
			9: begin
				ending = "end after name";
				send_text("abc");
			end
			10: begin
				ending = "end after regex";
				send_text("/a/");
			end
			11: ending = "end between tokens";
			12: begin
				ending = "open exclusion";
				send_text("[/a");
			end
			default: begin
				ending = "open regex";
				send_text("/ab");
			end
		endcase
		send_char(8'($urandom_range(255)), 1'b1);
		repeat (6)
			send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_tokens();
		test_strings();
		test_regex_and_lookahead();
		test_exclusion();
		test_comment();
		drain_wait();
		test_random_grammar();
		test_stream_end();
		drain_wait();
		repeat (8) @(posedge clk);
		if (expected.size() != 0) begin
			failures++;
			$display("%0t: pending token items expected 0, got %0d", $time, expected.size());
		end
		$display("Lexed %0d characters of grammar text and checked %0d token items.",
			sent_chars, checked);
		$display("The stream was closed by: %s.", ending);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
